>>> sv/aplm_pkg.sv
`timescale 1ns / 1ps
package aplm_pkg;

  typedef enum logic [3:0] {
    OP_INIT = 4'd0,
    OP_SHR  = 4'd1,
    OP_SHL  = 4'd2,
    OP_OR   = 4'd3,
    OP_AND  = 4'd4,
    OP_XOR  = 4'd5,
    OP_NOT  = 4'd6,
    OP_SUB  = 4'd7,
    OP_ADD  = 4'd8,
    OP_DIV  = 4'd9
  } opcode_t;

  localparam logic [1:0] MODEL_HW    = 2'd0;
  localparam logic [1:0] MODEL_HDL   = 2'd1;
  localparam logic [1:0] MODEL_HDR   = 2'd2;
  localparam logic [1:0] MODEL_BYTES = 2'd3;

  localparam logic CFG_MODEL  = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  // One finished operation handed from front to back
  typedef struct packed {
    logic [31:0] res;
    logic [31:0] ref_word;
    logic        use_ref;
  } job_t;

  // Count ones in a byte
  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) n = n + {3'd0, v[i]};
    return n;
  endfunction

endpackage

>>> sv/aplm_divider.sv
`timescale 1ns / 1ps
module aplm_divider import aplm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  count;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dsr};
  assign quotient = quo;

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/aplm_front.sv
`timescale 1ns / 1ps
module aplm_front import aplm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [31:0] left_operand,
  input  logic [31:0] right_operand,
  input  logic [1:0]  model,
  output logic        job_valid,
  input  logic        job_stall,
  output job_t        job
);

  logic        div_busy;
  logic        div_done;
  logic [31:0] div_q;
  logic        div_start;
  logic [31:0] div_ref;
  logic        div_use;
  logic        accept;
  job_t        comb_job;
  logic        is_div;

  assign accept = in_valid && !in_stall;
  assign is_div = (opcode == OP_DIV) && (right_operand != 32'd0);
  assign div_start = accept && is_div;

  // Stall while a divide runs or the output register is held
  assign in_stall = div_busy || div_done || (job_valid && job_stall);

  aplm_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(left_operand), .divisor(right_operand),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // Compute result and reference word for every opcode; a nonzero divide takes only its reference word from here
  always_comb begin
    comb_job.res = 32'd0;
    comb_job.ref_word = 32'd0;
    comb_job.use_ref = (model == MODEL_HDL) || (model == MODEL_HDR);
    case (opcode)
      OP_INIT: comb_job.res = left_operand;
      OP_SHR: comb_job.res = (right_operand[31:5] != 27'd0) ? 32'd0
                             : left_operand >> right_operand[4:0];
      OP_SHL: comb_job.res = (right_operand[31:5] != 27'd0) ? 32'd0
                             : left_operand << right_operand[4:0];
      OP_OR:  comb_job.res = left_operand | right_operand;
      OP_AND: comb_job.res = left_operand & right_operand;
      OP_XOR: comb_job.res = left_operand ^ right_operand;
      OP_NOT: comb_job.res = ~left_operand;
      OP_SUB: comb_job.res = left_operand - right_operand;
      OP_ADD: comb_job.res = left_operand + right_operand;
      OP_DIV: comb_job.res = 32'hFFFF_FFFF;
      default: comb_job.res = 32'd0;
    endcase
    if (model == MODEL_HDL) begin
      case (opcode)
        OP_SHR, OP_SHL, OP_OR, OP_AND, OP_XOR, OP_NOT, OP_SUB, OP_ADD, OP_DIV:
          comb_job.ref_word = left_operand;
        default: comb_job.ref_word = 32'd0;
      endcase
    end else begin
      case (opcode)
        OP_SHR, OP_SHL, OP_OR, OP_AND, OP_XOR, OP_SUB, OP_ADD, OP_DIV:
          comb_job.ref_word = right_operand;
        OP_NOT: comb_job.ref_word = left_operand;
        default: comb_job.ref_word = 32'd0;
      endcase
    end
  end

  // Register the job; divides land when the divider finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= div_done || (accept && !is_div) || (job_valid && job_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_div) job <= comb_job;
    if (div_start) begin
      div_ref <= comb_job.ref_word;
      div_use <= comb_job.use_ref;
    end
    if (div_done) begin
      job.res <= div_q;
      job.ref_word <= div_ref;
      job.use_ref <= div_use;
    end
  end

endmodule

>>> sv/aplm_queue.sv
`timescale 1ns / 1ps
module aplm_queue import aplm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_stall,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_take,
  output job_t rd_data
);

  job_t mem [QueueDepth];
  logic [QueuePtrW-1:0] wptr;
  logic [QueuePtrW-1:0] rptr;
  logic [QueuePtrW:0]   fill;
  logic wr;
  logic rd;

  assign wr_stall = (fill == (QueuePtrW + 1)'(QueueDepth));
  assign rd_valid = (fill != '0);
  assign rd_data = mem[rptr];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && rd_take;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      fill <= fill + {{QueuePtrW{1'b0}}, wr} - {{QueuePtrW{1'b0}}, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_data;
  end

endmodule

>>> sv/aplm_back.sv
`timescale 1ns / 1ps
module aplm_back import aplm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_take,
  input  job_t        job,
  input  logic [1:0]  model,
  input  logic        enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] op_result,
  output logic [5:0]  sample,
  output logic        sample_valid,
  output logic        last
);

  logic [1:0]  beat;
  logic [31:0] word;
  logic [5:0]  s_next;
  logic        last_next;
  logic        load;
  logic [7:0]  bsel;

  assign word = job.use_ref ? (job.res ^ job.ref_word) : job.res;
  assign load = job_valid && (!out_valid || !out_stall);
  assign last_next = !enable || (model != MODEL_BYTES) || (beat == 2'd3);
  assign job_take = load && last_next;

  always_comb begin
    case (beat)
      2'd0: bsel = job.res[7:0];
      2'd1: bsel = job.res[15:8];
      2'd2: bsel = job.res[23:16];
      default: bsel = job.res[31:24];
    endcase
    if (!enable) s_next = 6'd0;
    else if (model == MODEL_BYTES) s_next = {2'd0, pop8(bsel)};
    else s_next = {2'd0, pop8(word[7:0])} + {2'd0, pop8(word[15:8])}
                + {2'd0, pop8(word[23:16])} + {2'd0, pop8(word[31:24])};
  end

  // Emit one sample per transfer, stepping bytes in byte mode
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat <= 2'd0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
      if (load) beat <= last_next ? 2'd0 : beat + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_result <= job.res;
      sample <= s_next;
      sample_valid <= enable;
      last <= last_next;
    end
  end

endmodule

>>> sv/alu_power_leakage_model.sv
`timescale 1ns / 1ps
// ALU with Hamming weight/distance leakage samples. Each operation yields one
// transfer, or four (low byte first) in per-byte mode with leakage enabled. Other
// opcodes are computed in the front and registered as a job; a nonzero divide
// runs in the bit-serial divider and stalls the input until it finishes. The
// back emits one transfer per cycle unless out_stall holds it. A two-entry
// queue separates the two halves.
module alu_power_leakage_model import aplm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  opcode,
  input  logic [31:0] left_operand,
  input  logic [31:0] right_operand,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] op_result,
  output logic [5:0]  sample,
  output logic        sample_valid,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);

  logic [1:0] leak_model;
  logic       leak_enable;
  logic fj_valid;
  logic fj_stall;
  job_t fj;
  logic qv;
  logic qtake;
  job_t qd;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      leak_model <= MODEL_HW;
      leak_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODEL: leak_model <= cfg_data;
        CFG_ENABLE: leak_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  aplm_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .left_operand(left_operand), .right_operand(right_operand),
    .model(leak_model), .job_valid(fj_valid), .job_stall(fj_stall), .job(fj)
  );

  aplm_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(fj_valid), .wr_stall(fj_stall), .wr_data(fj),
    .rd_valid(qv), .rd_take(qtake), .rd_data(qd)
  );

  aplm_back u_back (
    .clk(clk), .rst(rst), .job_valid(qv), .job_take(qtake), .job(qd),
    .model(leak_model), .enable(leak_enable), .out_valid(out_valid),
    .out_stall(out_stall), .op_result(op_result), .sample(sample),
    .sample_valid(sample_valid), .last(last)
  );

endmodule

>>> sv/aplm_checker.sv
`timescale 1ns / 1ps
module aplm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] op_result,
  input logic [5:0]  sample,
  input logic        sample_valid,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(op_result) && $stable(sample))
    else $error("stalled output changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample <= 6'd32)
    else $error("sample out of range");

  a_pause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> last && sample == 6'd0)
    else $error("paused item malformed");

  a_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> sample <= 6'd8 && sample_valid)
    else $error("byte sample malformed");

endmodule

bind alu_power_leakage_model aplm_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .op_result(op_result), .sample(sample), .sample_valid(sample_valid), .last(last)
);
